[sv/circular_deque_unit_macros.svh]
// ----------------------------------------------------------------------------
// circular_deque_unit_macros: assertion macros
// Short forms for the concurrent checks of the deque block.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_MACROS_SVH
`define CIRCULAR_DEQUE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque block.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int CDQ_DEPTH     = 64;
	localparam int CDQ_DATA_W    = 32;
	localparam int CDQ_OP_W      = 3;
	localparam int CDQ_CAP_W     = 7;
	localparam int CDQ_CAP_RESET = 64;

	localparam logic [CDQ_DATA_W-1:0] CDQ_EMPTY_VALUE = '1;

	typedef enum logic [CDQ_OP_W-1:0] {
		OP_PEEK       = 3'd0,
		OP_INS_FRONT  = 3'd1,
		OP_INS_REAR   = 3'd2,
		OP_DEL_FRONT  = 3'd3,
		OP_DEL_REAR   = 3'd4
	} cdq_op_t;

	typedef struct packed {
		logic                 success;
		logic                 is_empty;
		logic                 is_full;
		logic [CDQ_CAP_W-1:0] entry_count;
	} cdq_status_t;

endpackage

[sv/cdq_ifs.sv]
// ----------------------------------------------------------------------------
// cdq_ifs
// Valid/ready channel interfaces: commands, responses and capacity writes.
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
	import cdq_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [CDQ_OP_W-1:0]          operation;
	logic signed [CDQ_DATA_W-1:0] data_value;

	modport source (output valid, output operation, output data_value, input ready);
	modport sink   (input valid, input operation, input data_value, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         success;
	logic signed [CDQ_DATA_W-1:0] front_value;
	logic signed [CDQ_DATA_W-1:0] rear_value;
	logic                         is_empty;
	logic                         is_full;
	logic [CDQ_CAP_W-1:0]         entry_count;

	modport source (output valid, output success, output front_value, output rear_value,
		output is_empty, output is_full, output entry_count, input ready);
	modport sink   (input valid, input success, input front_value, input rear_value,
		input is_empty, input is_full, input entry_count, output ready);
endinterface

interface cdq_cfg_if;
	import cdq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CDQ_CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface

[sv/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Bounded double-ended queue in a ring store, one operation per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one operation (peek, insert front/rear, delete front/rear)
//   and the value to insert. Each command transfer yields exactly one rsp
//   transfer with success, front and rear values (-1 when empty), the empty
//   and full flags and the entry count, all as they stand after the command.
//   cfg writes the capacity (0 taken as 1, above DEPTH taken as DEPTH) and
//   empties the deque; write it only while no response is pending.
// Timing:
//   One command per cycle sustained while rsp is taken. The command
//   transfer edge updates the pointers, writes the store and starts the
//   registered read of the new front and rear entries; the response
//   register loads from the read stage when that stage advances, and
//   rsp.valid is driven from that register.
// Reset:
//   arst_n empties the deque, sets the capacity to 64 (or DEPTH if smaller)
//   and drops any pending response. The store itself is not cleared.
// Stalls:
//   When rsp is not taken, the response register holds and the read stage
//   behind it fills; cmd.ready then drops until rsp moves again.
// ----------------------------------------------------------------------------
`include "circular_deque_unit_macros.svh"

module circular_deque_unit #(
	parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	cdq_cmd_if.sink   cmd,
	cdq_rsp_if.source rsp,
	cdq_cfg_if.sink   cfg
);
	import cdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  cmd_take, s1_adv;
	cdq_status_t           status, status_s1;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, rd_head, rd_tail;
	logic [CDQ_DATA_W-1:0] ram_wdata, front_rdata, rear_rdata;
	logic                  s1_valid_s1, byp_front_s1, byp_rear_s1;
	logic [CDQ_DATA_W-1:0] byp_data_s1, front_sel, rear_sel;
	logic                  rsp_valid_q;

	// capacity writes are always taken
	assign cfg.ready = 1'b1;

	// the read stage moves when the response register is free or being drained
	assign s1_adv    = !rsp_valid_q || rsp.ready;
	assign cmd.ready = !s1_valid_s1 || s1_adv;
	assign cmd_take  = cmd.valid && cmd.ready;

	cdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_cap   (cfg.capacity),
		.op_take   (cmd_take),
		.operation (cmd.operation),
		.data_value(cmd.data_value),
		.status    (status),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.rd_head   (rd_head),
		.rd_tail   (rd_tail)
	);

	// two copies of the store give independent front and rear read ports
	cdq_ram #(
		.WIDTH(CDQ_DATA_W),
		.DEPTH(DEPTH)
	) u_ram_front (
		.clk  (clk),
		.we   (ram_we && cmd_take),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd_take),
		.raddr(rd_head),
		.rdata(front_rdata)
	);

	cdq_ram #(
		.WIDTH(CDQ_DATA_W),
		.DEPTH(DEPTH)
	) u_ram_rear (
		.clk  (clk),
		.we   (ram_we && cmd_take),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd_take),
		.raddr(rd_tail),
		.rdata(rear_rdata)
	);

	// read stage: the RAM returns the old word on a same-cycle write,
	// so remember when the new front or rear is the word just written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			status_s1    <= status;
			byp_front_s1 <= ram_we && (rd_head == ram_waddr);
			byp_rear_s1  <= ram_we && (rd_tail == ram_waddr);
			byp_data_s1  <= ram_wdata;
		end
	end

	assign front_sel = status_s1.is_empty ? CDQ_EMPTY_VALUE :
		(byp_front_s1 ? byp_data_s1 : front_rdata);
	assign rear_sel  = status_s1.is_empty ? CDQ_EMPTY_VALUE :
		(byp_rear_s1 ? byp_data_s1 : rear_rdata);

	// response register: load when the read stage advances, hold otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			rsp.success     <= status_s1.success;
			rsp.front_value <= front_sel;
			rsp.rear_value  <= rear_sel;
			rsp.is_empty    <= status_s1.is_empty;
			rsp.is_full     <= status_s1.is_full;
			rsp.entry_count <= status_s1.entry_count;
		end
	end

	assign rsp.valid = rsp_valid_q;

	// a stalled read-stage item must stay put until the response register frees
	`CDQ_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_s1 && !s1_adv, s1_valid_s1,
		"read stage dropped a stalled item")
	// a successful insert always leaves the deque non-empty
	`CDQ_ASSERT_SAME(a_ins_nonempty, clk, arst_n,
		cmd_take && status.success && (cmd.operation == OP_INS_FRONT ||
		cmd.operation == OP_INS_REAR), !status.is_empty,
		"insert left the deque empty")
	// capacity is at least one, so full and empty never coincide
	`CDQ_ASSERT_SAME(a_full_empty, clk, arst_n, s1_valid_s1,
		!(status_s1.is_full && status_s1.is_empty),
		"full and empty flagged together")

endmodule

[sv/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

[sv/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head, tail, count and capacity registers with the per-operation update.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::CDQ_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [cdq_pkg::CDQ_CAP_W-1:0]            cfg_cap,
	input  logic                                     op_take,
	input  logic [cdq_pkg::CDQ_OP_W-1:0]             operation,
	input  logic [cdq_pkg::CDQ_DATA_W-1:0]           data_value,
	output cdq_pkg::cdq_status_t                     status,
	output logic                                     ram_we,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
	output logic [cdq_pkg::CDQ_DATA_W-1:0]           ram_wdata,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_head,
	output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_tail
);
	import cdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = ((AW > CDQ_CAP_W) ? AW : CDQ_CAP_W) + 1;
	localparam logic [CDQ_CAP_W-1:0] CAP_MAX =
		CDQ_CAP_W'((DEPTH < 127) ? DEPTH : 127);
	localparam logic [CDQ_CAP_W-1:0] CAP_RST =
		CDQ_CAP_W'((CDQ_CAP_RESET > DEPTH) ? DEPTH : CDQ_CAP_RESET);
	localparam logic [AW-1:0] TAIL_RST = AW'(CAP_RST - CDQ_CAP_W'(1));

	logic [AW-1:0]        head_q, tail_q, head_d, tail_d;
	logic [CDQ_CAP_W-1:0] count_q, count_d, cap_q, cap_w;
	logic                 full, empty, ok;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx,
		input logic [CDQ_CAP_W-1:0] cap);
		logic [XW-1:0] nxt;
		nxt = XW'(idx) + XW'(1);
		return (nxt >= XW'(cap)) ? '0 : nxt[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx,
		input logic [CDQ_CAP_W-1:0] cap);
		logic [XW-1:0] last;
		last = XW'(cap) - XW'(1);
		return (idx == '0 || XW'(idx) >= XW'(cap)) ? last[AW-1:0] : idx - AW'(1);
	endfunction

	// clamp a written capacity into one .. DEPTH
	always_comb begin
		cap_w = cfg_cap;
		if (cap_w == '0) begin
			cap_w = CDQ_CAP_W'(1);
		end else if (cap_w > CAP_MAX) begin
			cap_w = CAP_MAX;
		end
	end

	assign full  = (count_q >= cap_q);
	assign empty = (count_q == '0);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		ok        = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		unique case (cdq_op_t'(operation))
			OP_PEEK: begin
				ok = 1'b1;
			end
			OP_INS_FRONT: begin
				if (!full) begin
					head_d    = step_down(head_q, cap_q);
					ram_waddr = head_d;
					ram_we    = 1'b1;
					count_d   = count_q + CDQ_CAP_W'(1);
					ok        = 1'b1;
				end
			end
			OP_INS_REAR: begin
				if (!full) begin
					tail_d    = step_up(tail_q, cap_q);
					ram_waddr = tail_d;
					ram_we    = 1'b1;
					count_d   = count_q + CDQ_CAP_W'(1);
					ok        = 1'b1;
				end
			end
			OP_DEL_FRONT: begin
				if (!empty) begin
					head_d  = step_up(head_q, cap_q);
					count_d = count_q - CDQ_CAP_W'(1);
					ok      = 1'b1;
				end
			end
			OP_DEL_REAR: begin
				if (!empty) begin
					tail_d  = step_down(tail_q, cap_q);
					count_d = count_q - CDQ_CAP_W'(1);
					ok      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata          = data_value;
	assign rd_head            = head_d;
	assign rd_tail            = tail_d;
	assign status.success     = ok;
	assign status.is_empty    = (count_d == '0);
	assign status.is_full     = (count_d == cap_q);
	assign status.entry_count = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RST;
			head_q  <= '0;
			tail_q  <= TAIL_RST;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cap_w;
			head_q  <= '0;
			tail_q  <= AW'(cap_w - CDQ_CAP_W'(1));
			count_q <= '0;
		end else if (op_take) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

endmodule
